[hw/rtl/mcbd_pkg.sv]
package mcbd_pkg;

  // Field widths fixed by the item format
  localparam int unsigned ChanW  = 5;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DelayW = 16;

  // Settle delay after reset, in ms
  localparam logic [DelayW-1:0] SettleReset = 16'd30;

  // Command field codes
  localparam logic CmdEdge = 1'b0;
  localparam logic CmdTick = 1'b1;

  // Depth of the queue between front and back (power of two)
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    KIND_EDGE = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  // Classified item handed from front to back
  typedef struct packed {
    kind_e             kind;
    logic [ChanW-1:0]  chan;
    logic              press;
    logic [TimeW-1:0]  stamp;
  } item_t;

endpackage

[hw/rtl/mcbd_ram.sv]
module mcbd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/mcbd_front.sv]
module mcbd_front import mcbd_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 32
) (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             command_i,
  input  logic [ChanW-1:0] channel_i,
  input  logic             level_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic             q_full_i,
  output logic             push_o,
  output item_t            item_o
);

  logic chan_ok;
  logic is_tick;

  assign is_tick    = (command_i == CmdTick);
  assign chan_ok    = ({27'd0, channel_i} < 32'(NUM_CHANNELS));
  assign in_ready_o = ~q_full_i;

  // Drop edges on channels that do not exist; they are accepted but not queued.
  assign push_o = in_valid_i & ~q_full_i & (is_tick | chan_ok);

  always_comb begin
    item_o.kind  = is_tick ? KIND_TICK : KIND_EDGE;
    item_o.chan  = channel_i;
    item_o.press = ~level_i;
    item_o.stamp = now_ms_i;
  end

endmodule

[hw/rtl/mcbd_queue.sv]
module mcbd_queue import mcbd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

[hw/rtl/mcbd_back.sv]
module mcbd_back import mcbd_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  item_t             q_item_i,
  output logic              q_pop_o,
  input  logic [DelayW-1:0] delay_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ChanW-1:0]  button_o,
  output logic              pressed_o,
  output logic              last_o
);

  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CntW = $clog2(NUM_CHANNELS + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [NUM_CHANNELS-1:0] valid_q, press_q;
  logic [CntW-1:0]         issue_q, issue_d;
  logic [IdxW-1:0]         chk_idx_q, chk_idx_d;
  logic [TimeW-1:0]        tick_now_q, tick_now_d;
  logic                    hold_v_q, hold_v_d;
  logic [ChanW-1:0]        hold_btn_q, hold_btn_d;
  logic                    hold_press_q, hold_press_d;

  logic                    out_v_q;
  logic [ChanW-1:0]        out_btn_q;
  logic                    out_press_q, out_last_q;
  logic                    out_push, out_free;
  logic [ChanW-1:0]        push_btn;
  logic                    push_press, push_last;

  logic                    ram_we, ram_re;
  logic [IdxW-1:0]         ram_waddr, ram_raddr;
  logic [TimeW-1:0]        ram_rdata;
  logic [IdxW+ChanW-1:0]   wr_wide, chk_wide;
  logic [ChanW-1:0]        chk_btn;
  logic [TimeW-1:0]        age;
  logic                    hit, stall, set_en, clr_en;

  mcbd_ram #(
    .Width (TimeW),
    .Depth (NUM_CHANNELS)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (q_item_i.stamp),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign wr_wide   = {{IdxW{1'b0}}, q_item_i.chan};
  assign ram_waddr = wr_wide[IdxW-1:0];
  assign chk_wide  = {{ChanW{1'b0}}, chk_idx_q};
  assign chk_btn   = chk_wide[ChanW-1:0];

  // Modular age of the entry under check against the tick time
  assign age      = tick_now_q - ram_rdata;
  assign hit      = valid_q[chk_idx_q] & (age > {{(TimeW-DelayW){1'b0}}, delay_i});
  assign out_free = ~out_v_q | out_ready_i;
  assign stall    = hit & hold_v_q & ~out_free;

  always_comb begin
    state_d      = state_q;
    issue_d      = issue_q;
    chk_idx_d    = chk_idx_q;
    tick_now_d   = tick_now_q;
    hold_v_d     = hold_v_q;
    hold_btn_d   = hold_btn_q;
    hold_press_d = hold_press_q;
    q_pop_o      = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = issue_q[IdxW-1:0];
    set_en       = 1'b0;
    clr_en       = 1'b0;
    out_push     = 1'b0;
    push_btn     = hold_btn_q;
    push_press   = hold_press_q;
    push_last    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.kind == KIND_EDGE) begin
            ram_we = 1'b1;
            set_en = 1'b1;
          end else begin
            tick_now_d = q_item_i.stamp;
            ram_re     = 1'b1;
            ram_raddr  = '0;
            chk_idx_d  = '0;
            issue_d    = CntW'(1);
            state_d    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!stall) begin
          if (hit) begin
            clr_en = 1'b1;
            // A newer report proves the held one is not the last of this tick.
            out_push     = hold_v_q;
            hold_v_d     = 1'b1;
            hold_btn_d   = chk_btn;
            hold_press_d = press_q[chk_idx_q];
          end
          if (issue_q == CntW'(NUM_CHANNELS)) begin
            state_d = S_FLUSH;
          end else begin
            ram_re    = 1'b1;
            chk_idx_d = issue_q[IdxW-1:0];
            issue_d   = issue_q + CntW'(1);
          end
        end
      end
      S_FLUSH: begin
        if (!hold_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_push  = 1'b1;
          push_last = 1'b1;
          hold_v_d  = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      press_q   <= '0;
      issue_q   <= '0;
      chk_idx_q <= '0;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      issue_q   <= issue_d;
      chk_idx_q <= chk_idx_d;
      hold_v_q  <= hold_v_d;
      if (set_en) begin
        valid_q[ram_waddr] <= 1'b1;
        press_q[ram_waddr] <= q_item_i.press;
      end
      if (clr_en) begin
        valid_q[chk_idx_q] <= 1'b0;
      end
      if (out_push) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tick_now_q   <= tick_now_d;
    hold_btn_q   <= hold_btn_d;
    hold_press_q <= hold_press_d;
    if (out_push) begin
      out_btn_q   <= push_btn;
      out_press_q <= push_press;
      out_last_q  <= push_last;
    end
  end

  assign out_valid_o = out_v_q;
  assign button_o    = out_btn_q;
  assign pressed_o   = out_press_q;
  assign last_o      = out_last_q;

endmodule

[hw/rtl/multi_channel_button_debouncer_unit.sv]
// Debounces up to NUM_CHANNELS buttons by timestamp. An edge beat (command 0)
// records a press (level 0) or release (level 1) and its time on its channel,
// replacing any edge still pending there; edges on channels at or above
// NUM_CHANNELS are dropped. A tick beat (command 1) scans the channels from 0
// upward and reports, once, every pending edge whose age (now_ms minus its
// stamp, modulo 2^32) is strictly greater than the settle delay; the final
// report of a tick carries last = 1, and a tick with nothing settled reports
// nothing. The settle delay register resets to 30 ms and is written through
// the cfg port; the user writes it only while the block is idle, which the
// block itself does not enforce. Items pass a two-deep queue into the
// execution engine, so the input takes up to two more beats while a report
// waits. An edge updates its channel while the engine is idle. A tick scans
// the channels in order, as the stamp memory gives one channel's stamp per
// cycle through its single read port while the output does not stall. Reports
// are held back by one so that last can be set, so each report leaves at the
// next settled channel or at the end of the scan.
module multi_channel_button_debouncer_unit import mcbd_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // settle delay write port
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [DelayW-1:0] cfg_data_i,
  // item input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic [ChanW-1:0]  channel_i,
  input  logic              level_i,
  input  logic [TimeW-1:0]  now_ms_i,
  // report output
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ChanW-1:0]  button_o,
  output logic              pressed_o,
  output logic              last_o
);

  logic [DelayW-1:0] delay_q;
  logic              q_push, q_full, q_valid, q_pop;
  item_t             q_in_item, q_out_item;

  // The user changes the delay only while idle; the block does not enforce this and takes every write at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= SettleReset;
    end else if (cfg_valid_i) begin
      delay_q <= cfg_data_i;
    end
  end

  // Front: accept and classify beats, drop edges on missing channels
  mcbd_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .channel_i  (channel_i),
    .level_i    (level_i),
    .now_ms_i   (now_ms_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .item_o     (q_in_item)
  );

  // Queue decouples input acceptance from edge updates and tick scans
  mcbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_out_item),
    .pop_i   (q_pop)
  );

  // Back: update pending edges, scan on ticks, drive the report register
  mcbd_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out_item),
    .q_pop_o     (q_pop),
    .delay_i     (delay_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .button_o    (button_o),
    .pressed_o   (pressed_o),
    .last_o      (last_o)
  );

endmodule

[tb/sv/tb_multi_channel_button_debouncer_unit.sv]
module tb_multi_channel_button_debouncer_unit;
  import mcbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumChans    = 32;
  // Up to three silent ticks (one in the engine, two queued) can remain once
  // all reports are taken
  localparam int unsigned DrainCycles = 3 * (NumChans + 2) + 16;
  localparam int unsigned PhaseBeats  = 16;

  // One settled-edge report as the block should present it
  typedef struct {
    logic [ChanW-1:0] button;
    logic             pressed;
    logic             last;
  } report_t;

  // Tracks the pending edge of every channel and the reports still owed
  class settle_board;
    logic [DelayW-1:0] delay_ms;
    bit                armed[NumChans];
    bit                is_press[NumChans];
    logic [TimeW-1:0]  stamp[NumChans];
    report_t           owed[$];
    int unsigned       mismatches;

    function new();
      delay_ms   = SettleReset;
      mismatches = 0;
      for (int i = 0; i < NumChans; i++) begin
        armed[i]    = 1'b0;
        is_press[i] = 1'b0;
        stamp[i]    = '0;
      end
    endfunction

    function void set_delay(logic [DelayW-1:0] value);
      delay_ms = value;
    endfunction

    function void note_item(logic cmd, logic [ChanW-1:0] ch, logic lvl,
                            logic [TimeW-1:0] stamp_ms);
      int unsigned     base;
      logic [TimeW-1:0] age;
      report_t         rep;
      if (cmd == CmdEdge) begin
        if (ch < NumChans) begin
          armed[ch]    = 1'b1;
          is_press[ch] = (lvl == 1'b0);
          stamp[ch]    = stamp_ms;
        end
      end else begin
        base = owed.size();
        for (int i = 0; i < NumChans; i++) begin
          if (armed[i]) begin
            age = stamp_ms - stamp[i];
            if (age > {{(TimeW-DelayW){1'b0}}, delay_ms}) begin
              rep.button  = i[ChanW-1:0];
              rep.pressed = is_press[i];
              rep.last    = 1'b0;
              owed.push_back(rep);
              armed[i] = 1'b0;
            end
          end
        end
        if (owed.size() > base) owed[owed.size()-1].last = 1'b1;
      end
    endfunction

    function void check_report(logic [ChanW-1:0] button, logic pressed, logic last);
      report_t exp_rep;
      if (owed.size() == 0) begin
        $error("unexpected report: button %0d pressed %0d last %0d", button, pressed, last);
        mismatches++;
        return;
      end
      exp_rep = owed.pop_front();
      if (button !== exp_rep.button) begin
        $error("button: expected %0d, got %0d", exp_rep.button, button);
        mismatches++;
      end
      if (pressed !== exp_rep.pressed) begin
        $error("pressed: expected %0d, got %0d", exp_rep.pressed, pressed);
        mismatches++;
      end
      if (last !== exp_rep.last) begin
        $error("last: expected %0d, got %0d", exp_rep.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [DelayW-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              command_i = CmdEdge;
  logic [ChanW-1:0]  channel_i = '0;
  logic              level_i = 1'b0;
  logic [TimeW-1:0]  now_ms_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [ChanW-1:0]  button_o;
  logic              pressed_o;
  logic              last_o;

  settle_board      board = new();
  logic [TimeW-1:0] ms_now;
  int unsigned      beats_sent = 0;
  bit               feed_quiet = 1'b0;
  bit               sink_quiet = 1'b0;

  multi_channel_button_debouncer_unit #(
    .NUM_CHANNELS(NumChans)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .channel_i  (channel_i),
    .level_i    (level_i),
    .now_ms_i   (now_ms_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .button_o   (button_o),
    .pressed_o  (pressed_o),
    .last_o     (last_o)
  );

  always #6 clk_i = ~clk_i;

  // Present one input beat. Called at a falling edge; returns at the falling
  // edge after acceptance with valid still high, so a back-to-back beat
  // never drops valid in between.
  task automatic send_item(logic cmd, logic [ChanW-1:0] ch, logic lvl,
                           logic [TimeW-1:0] stamp_ms);
    int unsigned gap;
    gap = feed_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    command_i  = cmd;
    channel_i  = ch;
    level_i    = lvl;
    now_ms_i   = stamp_ms;
    in_valid_i = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    board.note_item(cmd, ch, lvl, stamp_ms);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every owed report, then let trailing ticks or
  // edges finish inside the engine.
  task automatic drain_block();
    in_valid_i = 1'b0;
    while (board.owed.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Write the settle delay; only called with the block idle
  task automatic write_delay(logic [DelayW-1:0] value);
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    board.set_delay(value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Random traffic: mostly bursts of edges followed by ticks placed right
  // around the settle boundary, with some full-width noise mixed in.
  task automatic run_phase(int unsigned budget);
    int unsigned goal;
    int unsigned pick;
    int unsigned n;
    goal = beats_sent + budget;
    while (beats_sent < goal) begin
      feed_quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        // press or release every channel at once, then settle them all
        for (int c = 0; c < NumChans; c++)
          send_item(CmdEdge, c[ChanW-1:0], 1'($urandom_range(0, 1)), ms_now);
        ms_now = ms_now + board.delay_ms + 1;
        send_item(CmdTick, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), ms_now);
      end else if (pick < 14) begin
        // bouncy burst: later edges on a channel cancel earlier ones
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_item(CmdEdge, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), ms_now);
          ms_now = ms_now + $urandom_range(0, 3);
        end
        // land the tick within a few ms of the boundary on either side
        ms_now = ms_now + board.delay_ms + $urandom_range(0, 6) - 3;
        send_item(CmdTick, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), ms_now);
        if ($urandom_range(0, 1) == 1) begin
          ms_now = ms_now + $urandom_range(1, 4);
          send_item(CmdTick, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), ms_now);
        end
      end else if (pick < 18) begin
        // noise: any command, any time, stamps in the future included
        send_item(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                  1'($urandom_range(0, 1)), $urandom());
      end else begin
        ms_now = ms_now + $urandom_range(0, 50);
        send_item(CmdTick, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), ms_now);
      end
    end
  endtask

  // Accept reports with random stalls, toggling into quiet stretches now
  // and then so back-to-back reports also occur.
  initial begin : report_sink
    int unsigned stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) sink_quiet = !sink_quiet;
      stall = sink_quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do begin
        @(posedge clk_i);
      end while (!out_valid_o);
      board.check_report(button_o, pressed_o, last_o);
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    // Hold reset low from time zero, release between edges
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part at the reset delay of 30 ms.
    // Tick with nothing pending
    send_item(CmdTick, 5'd0, 1'b0, 32'd0);
    // Edge stamped at time zero, and an edge stamped in the future
    send_item(CmdEdge, 5'd0, 1'b0, 32'd0);
    send_item(CmdEdge, 5'd31, 1'b1, 32'd100);
    // Age exactly 30 holds channel 0; the future stamp counts as settled
    send_item(CmdTick, 5'd31, 1'b1, 32'd30);
    send_item(CmdTick, 5'd0, 1'b0, 32'd31);
    // Bounce: the release replaces the press before it settles
    send_item(CmdEdge, 5'd5, 1'b0, 32'd1000);
    send_item(CmdEdge, 5'd5, 1'b1, 32'd1010);
    send_item(CmdTick, 5'd0, 1'b0, 32'd1040);
    send_item(CmdTick, 5'd0, 1'b0, 32'd1041);
    // Ages across the 32-bit wrap
    send_item(CmdEdge, 5'd17, 1'b0, 32'hFFFF_FFF0);
    send_item(CmdEdge, 5'd18, 1'b1, 32'hFFFF_FFFF);
    send_item(CmdTick, 5'd0, 1'b0, 32'h0000_000F);
    send_item(CmdTick, 5'd0, 1'b0, 32'h0000_0030);
    // Several channels settle in one scan; one stays pending
    send_item(CmdEdge, 5'd1, 1'b0, 32'd2000);
    send_item(CmdEdge, 5'd30, 1'b0, 32'd2000);
    send_item(CmdEdge, 5'd16, 1'b1, 32'd2005);
    send_item(CmdTick, 5'd0, 1'b0, 32'd2031);
    send_item(CmdTick, 5'd0, 1'b0, 32'd2036);
    send_item(CmdTick, 5'd31, 1'b1, 32'd5000);
    // Alternating bit patterns on the time field
    send_item(CmdEdge, 5'd10, 1'b0, 32'hAAAA_AAAA);
    send_item(CmdEdge, 5'd21, 1'b1, 32'h5555_5555);
    send_item(CmdTick, 5'd0, 1'b0, 32'hFFFF_FFFF);
    drain_block();

    // Random phases, each under its own delay, extremes first
    write_delay('0);
    ms_now = $urandom();
    run_phase(PhaseBeats);
    drain_block();

    write_delay('1);
    ms_now = $urandom();
    run_phase(PhaseBeats);
    drain_block();

    write_delay(DelayW'($urandom_range(2, 300)));
    ms_now = $urandom();
    run_phase(PhaseBeats);
    drain_block();

    // Start just short of the wrap so the phase crosses it
    write_delay(16'd1000);
    ms_now = 32'hFFFF_F000;
    run_phase(PhaseBeats);
    drain_block();

    write_delay(DelayW'($urandom_range(0, 65535)));
    ms_now = $urandom();
    run_phase(PhaseBeats);
    drain_block();

    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
